// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the ray/sphere intersection RTL.
// Each expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define RSI_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle, off during reset
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rsi_pkg.sv -----
// Types and constants for the ray/sphere intersection pipeline.
// No dependencies; used by every other RTL file except assert_macros.svh.
package rsi_pkg;

    localparam int DATA_W  = 32;
    localparam int RAD_W   = 31;
    localparam int V_W     = DATA_W + 1;
    localparam int PROD_W  = V_W + DATA_W;
    // b holds three products shifted down by at least eight fraction bits
    localparam int B_W     = 60;
    localparam int T_W     = B_W + 1;
    localparam int SQ_W    = 64;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int CFG_IDX_W = 2;
    localparam int SQRT_STEPS_PER_STAGE = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X  = 2'd0,
        REG_CENTER_Y  = 2'd1,
        REG_CENTER_Z  = 2'd2,
        REG_RADIUS_SQ = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_MISS       = 2'd0,
        KIND_HIT        = 2'd1,
        KIND_HIT_INSIDE = 2'd2
    } hit_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    typedef struct packed {
        vec_t                     origin;
        vec_t                     dir;
        logic signed [DATA_W-1:0] nearest;
    } ray_t;

    typedef struct packed {
        vec_t              center;
        logic [RAD_W-1:0]  radius_squared;
    } sphere_t;

    typedef struct packed {
        logic signed [B_W-1:0]    b;
        logic signed [DATA_W-1:0] nearest;
        logic                     disc_pos;
    } ray_side_t;

    typedef struct packed {
        ray_side_t        side;
        logic [SQ_W-1:0]  disc;
    } disc_beat_t;

    typedef struct packed {
        ray_side_t          side;
        logic [ROOT_W-1:0]  root;
    } root_beat_t;

    typedef struct packed {
        hit_kind_t                kind;
        logic signed [DATA_W-1:0] distance;
    } result_t;

endpackage

// ----- hdl/rsi_if.sv -----
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on rsi_pkg for field widths.
interface rsi_ray_if;
    logic                              valid;
    logic                              ready;
    logic signed [rsi_pkg::DATA_W-1:0] origin_x;
    logic signed [rsi_pkg::DATA_W-1:0] origin_y;
    logic signed [rsi_pkg::DATA_W-1:0] origin_z;
    logic signed [rsi_pkg::DATA_W-1:0] dir_x;
    logic signed [rsi_pkg::DATA_W-1:0] dir_y;
    logic signed [rsi_pkg::DATA_W-1:0] dir_z;
    logic signed [rsi_pkg::DATA_W-1:0] nearest_in;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_in,
        input  ready
    );
    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, nearest_in,
        output ready
    );
endinterface

interface rsi_hit_if;
    logic                                   valid;
    logic                                   ready;
    logic [$bits(rsi_pkg::hit_kind_t)-1:0]  hit_kind;
    logic signed [rsi_pkg::DATA_W-1:0]      nearest_out;

    modport source (
        output valid, hit_kind, nearest_out,
        input  ready
    );
    modport sink (
        input  valid, hit_kind, nearest_out,
        output ready
    );
endinterface

// ----- hdl/rsi_front.sv -----
// Front end: offset vector, dot products, b, squares and discriminant.
// Five register stages under a shared advance; depends on rsi_pkg.
module rsi_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  rsi_pkg::sphere_t    sphere,
    input  logic                in_valid,
    input  rsi_pkg::ray_t       in_ray,
    output logic                out_valid,
    output rsi_pkg::disc_beat_t out_beat
);

    localparam int NS = 5;

    logic [NS-1:0] vld_reg;

    // stage 1
    logic signed [rsi_pkg::V_W-1:0]    v_next   [3];
    logic signed [rsi_pkg::V_W-1:0]    v_reg    [3];
    logic signed [rsi_pkg::DATA_W-1:0] dir_next [3];
    logic signed [rsi_pkg::DATA_W-1:0] dir_reg  [3];
    logic signed [rsi_pkg::DATA_W-1:0] near_s1_reg;

    // stage 2
    logic signed [rsi_pkg::PROD_W-1:0] prod_next [3];
    logic signed [rsi_pkg::PROD_W-1:0] prod_reg  [3];
    logic [rsi_pkg::DATA_W-1:0]        vmag      [3];
    logic [rsi_pkg::SQ_W-1:0]          vsq_next  [3];
    logic [rsi_pkg::SQ_W-1:0]          vsq_reg   [3];
    logic signed [rsi_pkg::DATA_W-1:0] near_s2_reg;

    // stage 3
    logic signed [rsi_pkg::PROD_W-1:0] prod_sh [3];
    logic signed [rsi_pkg::B_W-1:0]    b_next;
    logic signed [rsi_pkg::B_W-1:0]    b_s3_reg;
    logic [rsi_pkg::SQ_W+1:0]          neg_sum;
    logic [rsi_pkg::SQ_W-1:0]          neg_next;
    logic [rsi_pkg::SQ_W-1:0]          neg_s3_reg;
    logic signed [rsi_pkg::DATA_W-1:0] near_s3_reg;

    // stage 4
    logic [rsi_pkg::B_W-1:0]           bmag;
    logic [rsi_pkg::SQ_W-1:0]          bsq_next;
    logic [rsi_pkg::SQ_W-1:0]          bsq_reg;
    logic signed [rsi_pkg::B_W-1:0]    b_s4_reg;
    logic [rsi_pkg::SQ_W-1:0]          neg_s4_reg;
    logic signed [rsi_pkg::DATA_W-1:0] near_s4_reg;

    // stage 5
    logic [rsi_pkg::SQ_W:0]            pos_sum;
    logic [rsi_pkg::SQ_W-1:0]          pos;
    rsi_pkg::disc_beat_t               beat_next;
    rsi_pkg::disc_beat_t               beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_comb
    begin
        v_next[0]   = rsi_pkg::V_W'($signed(in_ray.origin.x))
                    - rsi_pkg::V_W'($signed(sphere.center.x));
        v_next[1]   = rsi_pkg::V_W'($signed(in_ray.origin.y))
                    - rsi_pkg::V_W'($signed(sphere.center.y));
        v_next[2]   = rsi_pkg::V_W'($signed(in_ray.origin.z))
                    - rsi_pkg::V_W'($signed(sphere.center.z));
        dir_next[0] = in_ray.dir.x;
        dir_next[1] = in_ray.dir.y;
        dir_next[2] = in_ray.dir.z;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = rsi_pkg::PROD_W'(v_reg[i]) * rsi_pkg::PROD_W'(dir_reg[i]);
            // |v| stays below 2^32, so the square never saturates
            vmag[i]      = v_reg[i][rsi_pkg::V_W-1] ? rsi_pkg::DATA_W'(-v_reg[i])
                                                    : rsi_pkg::DATA_W'(v_reg[i]);
            vsq_next[i]  = rsi_pkg::SQ_W'(vmag[i]) * rsi_pkg::SQ_W'(vmag[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_sh[i] = prod_reg[i] >>> FRAC_BITS;
        end
        b_next   = -(rsi_pkg::B_W'(prod_sh[0]) + rsi_pkg::B_W'(prod_sh[1])
                   + rsi_pkg::B_W'(prod_sh[2]));
        neg_sum  = (rsi_pkg::SQ_W+2)'(vsq_reg[0]) + (rsi_pkg::SQ_W+2)'(vsq_reg[1])
                 + (rsi_pkg::SQ_W+2)'(vsq_reg[2]);
        neg_next = (|neg_sum[rsi_pkg::SQ_W+1:rsi_pkg::SQ_W]) ? '1
                                                             : neg_sum[rsi_pkg::SQ_W-1:0];
    end

    always_comb
    begin
        bmag     = b_s3_reg[rsi_pkg::B_W-1] ? rsi_pkg::B_W'(-b_s3_reg)
                                            : rsi_pkg::B_W'(b_s3_reg);
        bsq_next = (|bmag[rsi_pkg::B_W-1:rsi_pkg::DATA_W])
                 ? '1
                 : rsi_pkg::SQ_W'(bmag[rsi_pkg::DATA_W-1:0])
                   * rsi_pkg::SQ_W'(bmag[rsi_pkg::DATA_W-1:0]);
    end

    always_comb
    begin
        pos_sum = (rsi_pkg::SQ_W+1)'(bsq_reg)
                + ((rsi_pkg::SQ_W+1)'(sphere.radius_squared) << FRAC_BITS);
        pos     = pos_sum[rsi_pkg::SQ_W] ? '1 : pos_sum[rsi_pkg::SQ_W-1:0];
        beat_next.side.b        = b_s4_reg;
        beat_next.side.nearest  = near_s4_reg;
        beat_next.side.disc_pos = pos > neg_s4_reg;
        beat_next.disc          = pos - neg_s4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i]    <= v_next[i];
                dir_reg[i]  <= dir_next[i];
                prod_reg[i] <= prod_next[i];
                vsq_reg[i]  <= vsq_next[i];
            end
            near_s1_reg <= in_ray.nearest;
            near_s2_reg <= near_s1_reg;
            b_s3_reg    <= b_next;
            neg_s3_reg  <= neg_next;
            near_s3_reg <= near_s2_reg;
            bsq_reg     <= bsq_next;
            b_s4_reg    <= b_s3_reg;
            neg_s4_reg  <= neg_s3_reg;
            near_s4_reg <= near_s3_reg;
            beat_reg    <= beat_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_beat  = beat_reg;

endmodule

// ----- hdl/rsi_sqrt.sv -----
// Pipelined integer square root of the discriminant, two result bits a stage.
// Carries the ray sideband alongside; depends on rsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsi_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rsi_pkg::disc_beat_t in_beat,
    output logic                out_valid,
    output rsi_pkg::root_beat_t out_beat
);

    localparam int NS    = rsi_pkg::SQRT_STAGES;
    localparam int STEPS = rsi_pkg::SQRT_STEPS_PER_STAGE;

    logic [NS-1:0]            vld_reg;
    logic [rsi_pkg::SQ_W-1:0] rem_reg  [NS];
    logic [rsi_pkg::SQ_W-1:0] res_reg  [NS];
    rsi_pkg::ray_side_t       side_reg [NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic [rsi_pkg::SQ_W-1:0] rem_in;
        logic [rsi_pkg::SQ_W-1:0] res_in;
        logic [rsi_pkg::SQ_W-1:0] rem_next;
        logic [rsi_pkg::SQ_W-1:0] res_next;
        rsi_pkg::ray_side_t       side_in;

        if (k == 0)
        begin : g_head
            assign rem_in  = in_beat.disc;
            assign res_in  = '0;
            assign side_in = in_beat.side;
        end
        else
        begin : g_body
            assign rem_in  = rem_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            logic [rsi_pkg::SQ_W-1:0] trial;
            logic [rsi_pkg::SQ_W-1:0] bit_val;
            rem_next = rem_in;
            res_next = res_in;
            for (int j = 0; j < STEPS; j++)
            begin
                bit_val = rsi_pkg::SQ_W'(1) << (rsi_pkg::SQ_W - 2 - 2 * (k * STEPS + j));
                trial   = res_next + bit_val;
                if (rem_next >= trial)
                begin
                    rem_next = rem_next - trial;
                    res_next = (res_next >> 1) + bit_val;
                end
                else
                begin
                    res_next = res_next >> 1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid     = vld_reg[NS-1];
    assign out_beat.side = side_reg[NS-1];
    assign out_beat.root = res_reg[NS-1][rsi_pkg::ROOT_W-1:0];

    `RSI_ASSERT_IMPLY(a_root_remainder, out_valid,
        rem_reg[NS-1] <= (res_reg[NS-1] << 1), "square root remainder exceeds twice the root")

endmodule

// ----- hdl/rsi_resolve.sv -----
// Root selection: forms near and far distances and picks the hit kind.
// Two register stages; depends on rsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsi_resolve (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  rsi_pkg::root_beat_t in_beat,
    output logic                out_valid,
    output rsi_pkg::result_t    out_res
);

    logic [1:0]                        vld_reg;
    logic signed [rsi_pkg::T_W-1:0]    t1_next;
    logic signed [rsi_pkg::T_W-1:0]    t2_next;
    logic signed [rsi_pkg::T_W-1:0]    t1_reg;
    logic signed [rsi_pkg::T_W-1:0]    t2_reg;
    logic signed [rsi_pkg::DATA_W-1:0] near_reg;
    logic                              disc_reg;
    logic signed [rsi_pkg::T_W-1:0]    near_ext;
    rsi_pkg::result_t                  res_next;
    rsi_pkg::result_t                  res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[0], in_valid};
        end
    end

    always_comb
    begin
        t1_next = rsi_pkg::T_W'($signed(in_beat.side.b))
                - rsi_pkg::T_W'($signed({1'b0, in_beat.root}));
        t2_next = rsi_pkg::T_W'($signed(in_beat.side.b))
                + rsi_pkg::T_W'($signed({1'b0, in_beat.root}));
    end

    always_comb
    begin
        near_ext          = rsi_pkg::T_W'(near_reg);
        res_next.kind     = rsi_pkg::KIND_MISS;
        res_next.distance = near_reg;
        if (disc_reg && (t2_reg > 0))
        begin
            if (t1_reg < 0)
            begin
                if (t2_reg < near_ext)
                begin
                    res_next.kind     = rsi_pkg::KIND_HIT_INSIDE;
                    res_next.distance = t2_reg[rsi_pkg::DATA_W-1:0];
                end
            end
            else if (t1_reg < near_ext)
            begin
                res_next.kind     = rsi_pkg::KIND_HIT;
                res_next.distance = t1_reg[rsi_pkg::DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            near_reg <= in_beat.side.nearest;
            disc_reg <= in_beat.side.disc_pos;
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_res   = res_reg;

    `RSI_ASSERT_IMPLY(a_hit_dist_positive,
        out_valid && (out_res.kind != rsi_pkg::KIND_MISS),
        !out_res.distance[rsi_pkg::DATA_W-1], "hit reported with a negative distance")

endmodule

// ----- hdl/ray_sphere_intersect_top.sv -----
// Ray/sphere intersection, one ray per beat, Q-format set by FRAC_BITS (8 to 24).
// The 16-stage square root sets the pipeline depth, between the front end and root selection.
// Throughput: one ray per cycle; on an output stall, input stays open till the skid fills.
// Reset: valid bits and skid flag cleared; centre and squared radius registers set to zero.
// Depends on rsi_pkg, rsi_if, rsi_front, rsi_sqrt, rsi_resolve and assert_macros.svh.
`include "assert_macros.svh"

module ray_sphere_intersect_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rsi_pkg::DATA_W-1:0]     cfg_data,
    rsi_ray_if.sink                        ray_in,
    rsi_hit_if.source                      ray_out
);

    logic signed [rsi_pkg::DATA_W-1:0] center_x_reg;
    logic signed [rsi_pkg::DATA_W-1:0] center_y_reg;
    logic signed [rsi_pkg::DATA_W-1:0] center_z_reg;
    logic [rsi_pkg::RAD_W-1:0]         radius_sq_reg;

    rsi_pkg::sphere_t    sphere;
    rsi_pkg::ray_t       in_ray;
    logic                adv;
    logic                disc_valid;
    rsi_pkg::disc_beat_t disc_beat;
    logic                root_valid;
    rsi_pkg::root_beat_t root_beat;
    logic                pipe_valid;
    rsi_pkg::result_t    pipe_res;
    logic                skid_full_reg;
    logic                skid_full_next;
    rsi_pkg::result_t    skid_reg;
    rsi_pkg::result_t    out_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            center_z_reg  <= '0;
            radius_sq_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rsi_pkg::cfg_index_t'(cfg_index))
                rsi_pkg::REG_CENTER_X:  center_x_reg  <= cfg_data;
                rsi_pkg::REG_CENTER_Y:  center_y_reg  <= cfg_data;
                rsi_pkg::REG_CENTER_Z:  center_z_reg  <= cfg_data;
                rsi_pkg::REG_RADIUS_SQ: radius_sq_reg <= cfg_data[rsi_pkg::RAD_W-1:0];
                default:                ;
            endcase
        end
    end

    assign sphere.center.x       = center_x_reg;
    assign sphere.center.y       = center_y_reg;
    assign sphere.center.z       = center_z_reg;
    assign sphere.radius_squared = radius_sq_reg;

    assign in_ray.origin.x = ray_in.origin_x;
    assign in_ray.origin.y = ray_in.origin_y;
    assign in_ray.origin.z = ray_in.origin_z;
    assign in_ray.dir.x    = ray_in.dir_x;
    assign in_ray.dir.y    = ray_in.dir_y;
    assign in_ray.dir.z    = ray_in.dir_z;
    assign in_ray.nearest  = ray_in.nearest_in;

    // advance the whole pipeline unless the skid register holds a beat
    assign adv          = !skid_full_reg;
    assign ray_in.ready = adv;

    rsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sphere    (sphere),
        .in_valid  (ray_in.valid),
        .in_ray    (in_ray),
        .out_valid (disc_valid),
        .out_beat  (disc_beat)
    );

    rsi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (disc_valid),
        .in_beat   (disc_beat),
        .out_valid (root_valid),
        .out_beat  (root_beat)
    );

    rsi_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (root_valid),
        .in_beat   (root_beat),
        .out_valid (pipe_valid),
        .out_res   (pipe_res)
    );

    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = !ray_out.ready;
        end
        else
        begin
            skid_full_next = pipe_valid && !ray_out.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_full_reg <= 1'b0;
        end
        else
        begin
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= pipe_res;
        end
    end

    assign out_sel             = skid_full_reg ? skid_reg : pipe_res;
    assign ray_out.valid       = skid_full_reg || pipe_valid;
    assign ray_out.hit_kind    = out_sel.kind;
    assign ray_out.nearest_out = out_sel.distance;

    `RSI_ASSERT_NEXT(a_hold_behind_skid, skid_full_reg && pipe_valid,
        pipe_valid && $stable(pipe_res), "pipeline moved while the skid register was full")

endmodule

// ----- bench/ray_hit_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the ray/sphere intersection block: mirrors the sphere registers,
// works out each ray's hit and compares it with the result beats in order.
// Depends on rsi_pkg.
module ray_hit_checker
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 ray_valid,
    input  logic                 ray_ready,
    input  ray_t                 ray_beat,
    input  logic                 hit_valid,
    input  logic                 hit_ready,
    input  logic [1:0]           hit_kind,
    input  logic [DATA_W-1:0]    nearest_out,
    output int                   mismatches,
    output int                   pending,
    output int                   misses,
    output int                   outside_hits,
    output int                   inside_hits
);

    typedef struct packed {
        hit_kind_t          kind;
        logic [DATA_W-1:0]  distance;
    } hit_expect_t;

    hit_expect_t      expected_hits[$];
    longint           centre_x = 0;
    longint           centre_y = 0;
    longint           centre_z = 0;
    logic [RAD_W-1:0] radius_sq = '0;
    int               bad_total = 0;
    int               miss_n = 0;
    int               outside_n = 0;
    int               inside_n = 0;

    function automatic logic [63:0] square_sat(longint x);
        logic [63:0] m;
        m = (x < 0) ? 64'(-x) : 64'(x);
        if (m > 64'hFFFF_FFFF)
            return '1;
        return m * m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] x);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] c;
        r = '0;
        for (int i = ROOT_W - 1; i >= 0; i--)
        begin
            c = r | (ROOT_W'(1) << i);
            if (64'(c) * 64'(c) <= x)
                r = c;
        end
        return r;
    endfunction

    function automatic hit_expect_t predict_hit(ray_t r);
        longint      vx;
        longint      vy;
        longint      vz;
        longint      b;
        longint      s;
        longint      t_near;
        longint      t_far;
        longint      limit;
        logic [63:0] pos;
        logic [63:0] neg;
        hit_expect_t res;
        vx = longint'($signed(r.origin.x)) - centre_x;
        vy = longint'($signed(r.origin.y)) - centre_y;
        vz = longint'($signed(r.origin.z)) - centre_z;
        b = -(((vx * longint'($signed(r.dir.x))) >>> FRAC_BITS)
            + ((vy * longint'($signed(r.dir.y))) >>> FRAC_BITS)
            + ((vz * longint'($signed(r.dir.z))) >>> FRAC_BITS));
        pos = add_sat(square_sat(b), 64'(radius_sq) << FRAC_BITS);
        neg = add_sat(add_sat(square_sat(vx), square_sat(vy)), square_sat(vz));
        limit = longint'($signed(r.nearest));
        res.kind = KIND_MISS;
        res.distance = r.nearest;
        if (pos > neg)
        begin
            s = longint'(floor_root(pos - neg));
            t_near = b - s;
            t_far = b + s;
            if (t_far > 0)
            begin
                if (t_near < 0)
                begin
                    if (t_far < limit)
                    begin
                        res.kind = KIND_HIT_INSIDE;
                        res.distance = t_far[DATA_W-1:0];
                    end
                end
                else if (t_near < limit)
                begin
                    res.kind = KIND_HIT;
                    res.distance = t_near[DATA_W-1:0];
                end
            end
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : watch
        hit_expect_t want;
        if (rst_n)
        begin
            if (hit_valid && hit_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    bad_total++;
                    if (bad_total <= 10)
                        $display("unexpected result beat: kind %0d nearest_out %h",
                                 hit_kind, nearest_out);
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit_kind !== want.kind || nearest_out !== want.distance)
                    begin
                        bad_total++;
                        if (bad_total <= 10)
                            $display("mismatch: expected kind %0d nearest %h, got kind %0d nearest %h",
                                     want.kind, want.distance, hit_kind, nearest_out);
                    end
                    case (want.kind)
                        KIND_HIT:        outside_n++;
                        KIND_HIT_INSIDE: inside_n++;
                        default:         miss_n++;
                    endcase
                end
            end
            if (ray_valid && ray_ready)
                expected_hits.push_back(predict_hit(ray_beat));
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_CENTER_X:  centre_x = longint'($signed(cfg_data));
                    REG_CENTER_Y:  centre_y = longint'($signed(cfg_data));
                    REG_CENTER_Z:  centre_z = longint'($signed(cfg_data));
                    REG_RADIUS_SQ: radius_sq = cfg_data[RAD_W-1:0];
                    default: ;
                endcase
            end
            mismatches   <= bad_total;
            pending      <= expected_hits.size();
            misses       <= miss_n;
            outside_hits <= outside_n;
            inside_hits  <= inside_n;
        end
    end

endmodule

// ----- bench/tb_ray_sphere_intersect_top.sv -----
`timescale 1ns / 100ps
// Testbench top for ray_sphere_intersect_top: drives sphere settings and rays,
// directed edge cases then random rays, with idling on both channels; gives the verdict.
// Depends on rsi_pkg, rsi_if, ray_sphere_intersect_top and ray_hit_checker.
module tb_ray_sphere_intersect_top;
    import rsi_pkg::*;

    localparam int                FRAC           = 16;
    localparam int                ONE            = 65536;
    localparam logic signed [31:0] FIX_MAX       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FIX_MIN       = 32'sh8000_0000;
    localparam logic [31:0]       RAD_SQ_MAX     = 32'h7FFF_FFFF;
    localparam int                CYCLE_LIMIT    = 1_000_000;
    localparam int                RANDOM_PHASES  = 5;
    localparam int                RAYS_PER_PHASE = 205;
    localparam int                SETTLE_CYCLES  = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    int  mismatches;
    int  pending;
    int  misses;
    int  outside_hits;
    int  inside_hits;
    int  rays_sent = 0;
    int  settings = 0;
    int  cycles = 0;
    bit  steady = 1'b0;
    real sphere_x = 0.0;
    real sphere_y = 0.0;
    real sphere_z = 0.0;
    real sphere_r = 1.0;

    rsi_ray_if ray_bus ();
    rsi_hit_if hit_bus ();

    ray_sphere_intersect_top #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ray_in    (ray_bus),
        .ray_out   (hit_bus)
    );

    ray_hit_checker #(
        .FRAC_BITS (FRAC)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ray_valid    (ray_bus.valid),
        .ray_ready    (ray_bus.ready),
        .ray_beat     ({ray_bus.origin_x, ray_bus.origin_y, ray_bus.origin_z,
                        ray_bus.dir_x, ray_bus.dir_y, ray_bus.dir_z, ray_bus.nearest_in}),
        .hit_valid    (hit_bus.valid),
        .hit_ready    (hit_bus.ready),
        .hit_kind     (hit_bus.hit_kind),
        .nearest_out  (hit_bus.nearest_out),
        .mismatches   (mismatches),
        .pending      (pending),
        .misses       (misses),
        .outside_hits (outside_hits),
        .inside_hits  (inside_hits)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("** ray_sphere_intersect_top: FAILED **");
            $finish;
        end
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int ready_run();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 6);
        if (roll < 92)
            return $urandom_range(7, 40);
        return $urandom_range(100, 400);
    endfunction

    function automatic real rand_real(real lo, real hi);
        return lo + (hi - lo) * (real'($urandom) / 4294967295.0);
    endfunction

    function automatic logic signed [31:0] fix(real v);
        real s;
        s = v * 65536.0;
        if (s > 2147483647.0)
            return FIX_MAX;
        if (s < -2147483648.0)
            return FIX_MIN;
        return $rtoi(s);
    endfunction

    function automatic void unit_dir(output real ux, output real uy, output real uz);
        real len;
        ux = rand_real(-1.0, 1.0);
        uy = rand_real(-1.0, 1.0);
        uz = rand_real(-1.0, 1.0);
        len = $sqrt(ux * ux + uy * uy + uz * uz);
        if (len < 1.0e-6)
        begin
            ux = 1.0;
            uy = 0.0;
            uz = 0.0;
        end
        else
        begin
            ux /= len;
            uy /= len;
            uz /= len;
        end
    endfunction

    function automatic ray_t make_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                                      logic signed [31:0] oz, logic signed [31:0] dx,
                                      logic signed [31:0] dy, logic signed [31:0] dz,
                                      logic signed [31:0] nearest);
        ray_t r;
        r.origin.x = ox;
        r.origin.y = oy;
        r.origin.z = oz;
        r.dir.x = dx;
        r.dir.y = dy;
        r.dir.z = dz;
        r.nearest = nearest;
        return r;
    endfunction

    // Mostly rays aimed at the current sphere, some from inside, some loose, some raw noise
    function automatic ray_t random_ray();
        real  ox;
        real  oy;
        real  oz;
        real  ux;
        real  uy;
        real  uz;
        real  tx;
        real  ty;
        real  tz;
        real  reach;
        real  len;
        int   roll;
        ray_t r;
        roll = $urandom_range(0, 99);
        if (roll >= 85)
        begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return r;
        end
        unit_dir(ux, uy, uz);
        if (roll < 55)
            reach = sphere_r * rand_real(0.2, 20.0);
        else if (roll < 70)
            reach = sphere_r * rand_real(0.0, 0.95);
        else
            reach = sphere_r * rand_real(0.0, 50.0);
        ox = sphere_x + ux * reach;
        oy = sphere_y + uy * reach;
        oz = sphere_z + uz * reach;
        unit_dir(ux, uy, uz);
        if (roll < 55)
        begin
            tx = sphere_x + sphere_r * rand_real(-0.9, 0.9) - ox;
            ty = sphere_y + sphere_r * rand_real(-0.9, 0.9) - oy;
            tz = sphere_z + sphere_r * rand_real(-0.9, 0.9) - oz;
            len = $sqrt(tx * tx + ty * ty + tz * tz);
            if (len > 1.0e-6)
            begin
                ux = tx / len;
                uy = ty / len;
                uz = tz / len;
            end
        end
        r.origin.x = fix(ox);
        r.origin.y = fix(oy);
        r.origin.z = fix(oz);
        r.dir.x = fix(ux);
        r.dir.y = fix(uy);
        r.dir.z = fix(uz);
        roll = $urandom_range(0, 99);
        if (roll < 40)
            r.nearest = FIX_MAX;
        else if (roll < 75)
            r.nearest = fix((reach + sphere_r) * rand_real(0.0, 1.6));
        else
            r.nearest = $urandom;
        return r;
    endfunction

    // Hold valid after the beat unless a gap follows
    task automatic launch_ray(input ray_t r);
        int gap;
        ray_bus.valid      <= 1'b1;
        ray_bus.origin_x   <= r.origin.x;
        ray_bus.origin_y   <= r.origin.y;
        ray_bus.origin_z   <= r.origin.z;
        ray_bus.dir_x      <= r.dir.x;
        ray_bus.dir_y      <= r.dir.y;
        ray_bus.dir_z      <= r.dir.z;
        ray_bus.nearest_in <= r.nearest;
        @(posedge clk);
        while (!ray_bus.ready)
            @(posedge clk);
        rays_sent++;
        gap = steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            ray_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_sphere(input logic [31:0] cx, input logic [31:0] cy,
                              input logic [31:0] cz, input logic [31:0] r2);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS_SQ, r2);
        cfg_wr_en <= 1'b0;
        settings++;
        sphere_x = real'($signed(cx)) / 65536.0;
        sphere_y = real'($signed(cy)) / 65536.0;
        sphere_z = real'($signed(cz)) / 65536.0;
        sphere_r = $sqrt(real'(r2[30:0]) / 65536.0);
        if (sphere_r < 0.01)
            sphere_r = 1.0;
    endtask

    // Drop valid and wait for every outstanding result beat
    task automatic drain();
        ray_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_sink
        hit_bus.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hit_bus.ready <= 1'b1;
            repeat (ready_run()) @(posedge clk);
            hit_bus.ready <= 1'b0;
            repeat (idle_gap() + 1) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        real radius;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        ray_bus.valid = 1'b0;
        ray_bus.origin_x = '0;
        ray_bus.origin_y = '0;
        ray_bus.origin_z = '0;
        ray_bus.dir_x = '0;
        ray_bus.dir_y = '0;
        ray_bus.dir_z = '0;
        ray_bus.nearest_in = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sphere: point at the origin
        launch_ray(make_ray(0, 0, 0, 0, 0, 0, 0));
        launch_ray(make_ray(-3 * ONE, 0, 0, ONE, 0, 0, FIX_MAX));

        drain();
        set_sphere(0, 0, 5 * ONE, ONE);
        launch_ray(make_ray(0, 0, 0, 0, 0, ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 0, 0, 0, ONE, 4 * ONE));
        launch_ray(make_ray(0, 0, 0, 0, 0, ONE, 4 * ONE + 1));
        launch_ray(make_ray(0, 0, 5 * ONE, 0, 0, ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 5 * ONE, 0, 0, ONE, ONE));
        launch_ray(make_ray(0, 0, 0, 0, 0, -ONE, FIX_MAX));
        launch_ray(make_ray(ONE, 0, 0, 0, 0, ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 4 * ONE, 0, 0, ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 6 * ONE, 0, 0, ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 0, 0, 0, 2 * ONE, FIX_MAX));
        launch_ray(make_ray(0, 0, 0, 0, 0, ONE, -ONE));
        launch_ray(make_ray(0, 0, 0, ONE, 0, 0, FIX_MAX));

        drain();
        set_sphere(FIX_MAX, FIX_MIN, FIX_MAX, RAD_SQ_MAX);
        launch_ray(make_ray(FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MAX));
        launch_ray(make_ray(FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX));
        launch_ray(make_ray(FIX_MAX, FIX_MIN, FIX_MAX, 0, 0, 0, FIX_MIN));
        launch_ray(make_ray(FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
        launch_ray(make_ray(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
        launch_ray(make_ray(FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX, FIX_MIN, 0));

        drain();
        set_sphere(FIX_MIN, FIX_MIN, FIX_MIN, RAD_SQ_MAX);
        launch_ray(make_ray(FIX_MIN, FIX_MIN, FIX_MIN, ONE, 0, 0, FIX_MAX));
        launch_ray(make_ray(FIX_MIN + 100 * ONE, FIX_MIN, FIX_MIN, -ONE, 0, 0, FIX_MAX));
        launch_ray(make_ray(0, 0, 0, -ONE, 0, 0, FIX_MAX));

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase == RANDOM_PHASES - 1)
                set_sphere($urandom, $urandom, $urandom, $urandom_range(0, RAD_SQ_MAX));
            else
            begin
                radius = ($urandom_range(0, 1) == 0) ? rand_real(0.5, 10.0)
                                                     : rand_real(10.0, 150.0);
                set_sphere(fix(rand_real(-2000.0, 2000.0)), fix(rand_real(-2000.0, 2000.0)),
                           fix(rand_real(-2000.0, 2000.0)), fix(radius * radius));
            end
            for (int n = 0; n < RAYS_PER_PHASE; n++)
            begin
                if (n % 64 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                launch_ray(random_ray());
            end
            steady = 1'b0;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d rays over %0d sphere settings: directed edge cases, then random rays",
                 rays_sent, settings);
        $display("with idling on both channels; %0d misses, %0d outside hits, %0d inside hits.",
                 misses, outside_hits, inside_hits);
        if (mismatches == 0)
            $display("** ray_sphere_intersect_top: PASSED **");
        else
            $display("** ray_sphere_intersect_top: FAILED **");
        $finish;
    end

endmodule
